FILE: hdl/rpbs_pkg.sv
// ----------------------------------------------------------------------------
// rpbs_pkg
// Shared types and constants of the rgb panel bit-plane scanner.
// ----------------------------------------------------------------------------
package rpbs_pkg;

  // panel geometry and color depth
  localparam int PANEL_WIDTH  = 64;
  localparam int PANEL_HEIGHT = 32;
  localparam int COLOR_PLANES = 8;

  localparam int ROW_PAIRS = PANEL_HEIGHT / 2;
  localparam int COL_W     = $clog2(PANEL_WIDTH);
  localparam int ROW_W     = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
  localparam int PLANE_W   = (COLOR_PLANES > 1) ? $clog2(COLOR_PLANES) : 1;

  // fixed field widths
  localparam int ADDR_W      = 11;
  localparam int STORE_DEPTH = 2048;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int WAIT_W      = 15;
  localparam int ROW_ADDR_W  = 4;
  localparam logic [CHAN_W-1:0] BASE_WAIT_RST = 8'd5;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_TICK  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    PH_SHIFT = 2'd0,
    PH_LATCH = 2'd1,
    PH_SHOW  = 2'd2
  } phase_e;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] pixel_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic                  upper_red;
    logic                  upper_green;
    logic                  upper_blue;
    logic                  lower_red;
    logic                  lower_green;
    logic                  lower_blue;
    logic                  shift_clock;
    logic                  latch_strobe;
    logic                  display_enable;
    logic [ROW_ADDR_W-1:0] row_address;
  } out_item_t;

  // classified command as it waits in the queue
  typedef struct packed {
    mode_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clear_busy;
  } back_stat_t;

endpackage

FILE: hdl/rgb_panel_bitplane_scan_unit.sv
// ----------------------------------------------------------------------------
// rgb_panel_bitplane_scan_unit
// LED matrix scanner with binary code modulation over a pixel frame store.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------
//  in       | in_valid_i / in_ready_o | in_data_i  (pixel write or tick)
//  out      | out_valid_o/out_ready_i | out_data_o (panel pin states)
//  cfg      | cfg_we_i                | cfg_wdata_i (base_wait)
//
// one word per cycle while the queue has room and the store clear is done;
// a tick's result passes a queue slot, then the store read into the result register
// after reset the whole frame store is zeroed with in_ready_o low
// a stalled output holds the result; the two-entry queue keeps taking words
// while the back end waits, and store writes proceed past a stalled result
// ----------------------------------------------------------------------------
module rgb_panel_bitplane_scan_unit import rpbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [CHAN_W-1:0] cfg_wdata_i
);

  q_head_t    head;
  back_stat_t stat;

  rpbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .stat_i     (stat),
    .head_o     (head)
  );

  rpbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/rpbs_front.sv
// ----------------------------------------------------------------------------
// rpbs_front
// Accepts input words, classifies them into store writes and scan ticks
// and holds them in a short command queue for the back end.
// ----------------------------------------------------------------------------
module rpbs_front import rpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  input  back_stat_t stat_i,
  output q_head_t    head_o
);

  op_t                q_mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               push;
  op_t                op_new;

  // nothing enters while the frame store is being cleared
  assign in_ready_o = (cnt_q < Q_CNT_W'(Q_DEPTH)) && !stat_i.clear_busy;
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    op_new.kind  = mode_e'(in_data_i.mode);
    op_new.addr  = in_data_i.pixel_index;
    op_new.pixel = {in_data_i.red, in_data_i.green, in_data_i.blue};
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (stat_i.pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, stat_i.pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= op_new;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = q_mem_q[rd_ptr_q];

  queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("command queue count out of range");

  pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.pop |-> cnt_q != '0)
    else $error("pop from empty command queue");

  queue_tracks_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !stat_i.pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

FILE: hdl/rpbs_back.sv
// ----------------------------------------------------------------------------
// rpbs_back
// Executes queued commands: pixel writes into the frame store and scan ticks
// through the shift, latch and display sequencer, with a registered result.
// ----------------------------------------------------------------------------
module rpbs_back import rpbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CHAN_W-1:0] cfg_wdata_i,
  input  q_head_t           head_i,
  output back_stat_t        stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  logic [PIX_W-1:0] store_mem [STORE_DEPTH];

  logic [CHAN_W-1:0]  base_wait_q;
  logic               clr_busy_q;
  logic [ADDR_W-1:0]  clr_addr_q;

  phase_e             phase_q, phase_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [WAIT_W-1:0]  wait_q, wait_d;

  logic               out_valid_q;
  logic               out_shift_q, out_latch_q, out_show_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [PLANE_W-1:0] out_plane_q;
  logic [PIX_W-1:0]   rd_up_q, rd_lo_q;

  logic               stage_free, pop, tick_fire, wr_fire;
  logic               shift_now, latch_now, show_now;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, addr_up, addr_lo;
  logic [PIX_W-1:0]   mem_wdata;

  assign stage_free = !out_valid_q || out_ready_i;
  assign pop = head_i.valid && !clr_busy_q &&
               ((head_i.op.kind == MODE_WRITE) || stage_free);
  assign tick_fire = pop && (head_i.op.kind == MODE_TICK);
  assign wr_fire   = pop && (head_i.op.kind == MODE_WRITE);

  assign stat_o.pop        = pop;
  assign stat_o.clear_busy = clr_busy_q;

  // store addresses of the upper and lower pixel, wrapped to the store
  assign addr_up = ADDR_W'(int'(row_q) * PANEL_WIDTH + int'(col_q));
  assign addr_lo = ADDR_W'((int'(row_q) + ROW_PAIRS) * PANEL_WIDTH + int'(col_q));

  // sequencer next state
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    plane_d = plane_q;
    row_d   = row_q;
    wait_d  = wait_q;
    if (tick_fire) begin
      unique case (phase_q)
        PH_LATCH: begin
          wait_d  = WAIT_W'({{(WAIT_W-CHAN_W){1'b0}}, base_wait_q} << plane_q);
          phase_d = PH_SHOW;
        end
        PH_SHOW: begin
          if (wait_q <= WAIT_W'(1)) begin
            wait_d  = '0;
            phase_d = PH_SHIFT;
            if (plane_q == PLANE_W'(COLOR_PLANES - 1)) begin
              plane_d = '0;
              row_d   = (row_q == ROW_W'(ROW_PAIRS - 1)) ? '0 : row_q + 1'b1;
            end else begin
              plane_d = plane_q + 1'b1;
            end
          end else begin
            wait_d = wait_q - 1'b1;
          end
        end
        default: begin
          if (col_q == COL_W'(PANEL_WIDTH - 1)) begin
            col_d   = '0;
            phase_d = PH_LATCH;
          end else begin
            col_d   = col_q + 1'b1;
            phase_d = PH_SHIFT;
          end
        end
      endcase
    end
  end

  // sequencer outputs
  always_comb begin
    shift_now = 1'b0;
    latch_now = 1'b0;
    show_now  = 1'b0;
    unique case (phase_q)
      PH_LATCH: latch_now = 1'b1;
      PH_SHOW:  show_now  = 1'b1;
      default:  shift_now = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SHIFT;
      col_q       <= '0;
      plane_q     <= '0;
      row_q       <= '0;
      wait_q      <= '0;
      base_wait_q <= BASE_WAIT_RST;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      plane_q <= plane_d;
      row_q   <= row_d;
      wait_q  <= wait_d;
      if (cfg_we_i) begin
        base_wait_q <= cfg_wdata_i;
      end
      // zero sweep over the whole store after reset
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (tick_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      out_shift_q <= shift_now;
      out_latch_q <= latch_now;
      out_show_q  <= show_now;
      out_row_q   <= row_q;
      out_plane_q <= plane_q;
    end
  end

  assign mem_we    = clr_busy_q || wr_fire;
  assign mem_waddr = clr_busy_q ? clr_addr_q : head_i.op.addr;
  assign mem_wdata = clr_busy_q ? '0 : head_i.op.pixel;

  // frame store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (tick_fire) begin
      rd_up_q <= store_mem[addr_up];
      rd_lo_q <= store_mem[addr_lo];
    end
  end

  always_comb begin
    out_data_o.upper_red      = out_shift_q && rd_up_q[2*CHAN_W + int'(out_plane_q)];
    out_data_o.upper_green    = out_shift_q && rd_up_q[CHAN_W + int'(out_plane_q)];
    out_data_o.upper_blue     = out_shift_q && rd_up_q[int'(out_plane_q)];
    out_data_o.lower_red      = out_shift_q && rd_lo_q[2*CHAN_W + int'(out_plane_q)];
    out_data_o.lower_green    = out_shift_q && rd_lo_q[CHAN_W + int'(out_plane_q)];
    out_data_o.lower_blue     = out_shift_q && rd_lo_q[int'(out_plane_q)];
    out_data_o.shift_clock    = out_shift_q;
    out_data_o.latch_strobe   = out_latch_q;
    out_data_o.display_enable = out_show_q;
    out_data_o.row_address    = ROW_ADDR_W'(out_row_q);
  end

  assign out_valid_o = out_valid_q;

  no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pop)
    else $error("command executed during store clear");

  latch_leads_to_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire && phase_q == PH_LATCH |=> phase_q == PH_SHOW)
    else $error("latch tick not followed by display phase");

  one_pin_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot({out_shift_q, out_latch_q, out_show_q}))
    else $error("result carries more than one phase strobe");

  idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_SHOW |-> wait_q == '0)
    else $error("display counter running outside display phase");

endmodule
